/* rtl/core/euler_to_rotation_matrix_core_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the Euler-angle rotation matrix core.
// Each macro expects clk and arst_n in scope.
// -----------------------------------------------------------------------------
`ifndef EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH
`define EULER_TO_ROTATION_MATRIX_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define E2R_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define E2R_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* rtl/core/e2r_pkg.sv */
// -----------------------------------------------------------------------------
// e2r_pkg
// Shared types and constants of the Euler-angle rotation matrix core.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package e2r_pkg;

	// Default widths.
	localparam int ANGLE_WIDTH_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 14;

	// Queue depths (powers of two).
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 32;

	// Internal angle and fixed-point format.
	localparam int TURN_W = 32;
	localparam int Q_BITS = 30;
	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [30:0] HALF_Q30 = 31'h2000_0000;

	// Reciprocal scaling for the divisions by small constants.
	localparam int RECIP_SHIFT = 33;

	// Polynomial evaluation structure.
	localparam int SIN_STEPS = 4;
	localparam int COS_STEPS = 5;
	localparam int STEP_LAT  = 3;

	// Pipeline latencies of the back end.
	localparam int TRIG_LAT = 4 + COS_STEPS * STEP_LAT + 1;
	localparam int MAT_LAT  = 4;
	localparam int BACK_LAT = TRIG_LAT + MAT_LAT;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// One angle folded into the first octant.
	typedef struct packed {
		quad_t       quad;
		logic        swap;
		logic [29:0] red;
	} angle_class_t;

	// One classified item as it waits between front and back.
	typedef struct packed {
		angle_class_t roll;
		angle_class_t pitch;
		angle_class_t yaw;
	} fold_item_t;

	// Divisors of the Horner steps of the sine series.
	function automatic logic [6:0] sin_div(input int k);
		logic [6:0] d;
		unique case (k)
			0:       d = 7'd72;
			1:       d = 7'd42;
			2:       d = 7'd20;
			3:       d = 7'd6;
			default: d = 7'd1;
		endcase
		return d;
	endfunction

	// Divisors of the Horner steps of the cosine series.
	function automatic logic [6:0] cos_div(input int k);
		logic [6:0] d;
		unique case (k)
			0:       d = 7'd90;
			1:       d = 7'd56;
			2:       d = 7'd30;
			3:       d = 7'd12;
			4:       d = 7'd2;
			default: d = 7'd1;
		endcase
		return d;
	endfunction

endpackage

/* rtl/core/e2r_fifo.sv */
// -----------------------------------------------------------------------------
// e2r_fifo
// Small flop-based first-in first-out queue; depth must be a power of two.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "euler_to_rotation_matrix_core_macros.svh"

module e2r_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = PTR_W + 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// Handshake qualification.
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage is written without reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`E2R_ASSERT(a_full_empty_excl, !(full && empty), "queue is full and empty at once")
	`E2R_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")
	`E2R_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

/* rtl/core/e2r_front.sv */
// -----------------------------------------------------------------------------
// e2r_front
// Accepts items, negates and folds each angle into the first octant, and
// queues the classified item for the back end.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2r_front import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [ANGLE_WIDTH-1:0] roll_angle,
	input  logic signed [ANGLE_WIDTH-1:0] pitch_angle,
	input  logic signed [ANGLE_WIDTH-1:0] yaw_angle,
	input  logic                          deq,
	output fold_item_t                    item,
	output logic                          item_empty
);

	localparam logic [29:0] RED_HALF = 30'h2000_0000;

	fold_item_t fold;

	// Negate the angle as a turn, take its quadrant and reflect the upper octant.
	function automatic angle_class_t classify(input logic [ANGLE_WIDTH-1:0] a);
		logic [TURN_W-1:0] turn;
		logic [29:0]       rem;
		logic [30:0]       refl;
		angle_class_t      c;
		turn   = TURN_W'(0) - (TURN_W'(a) << (TURN_W - ANGLE_WIDTH));
		rem    = turn[29:0];
		refl   = ONE_Q30 - 31'(rem);
		c.quad = quad_t'(turn[31:30]);
		c.swap = (rem > RED_HALF);
		c.red  = c.swap ? refl[29:0] : rem;
		return c;
	endfunction

	always_comb begin
		fold.roll  = classify(roll_angle);
		fold.pitch = classify(pitch_angle);
		fold.yaw   = classify(yaw_angle);
	end

	// Queue between front and back.
	e2r_fifo #(
		.WIDTH ($bits(fold_item_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (fold),
		.full    (full),
		.pop     (deq),
		.rd_data (item),
		.empty   (item_empty)
	);

endmodule

/* rtl/core/e2r_trig.sv */
// -----------------------------------------------------------------------------
// e2r_trig
// Pipelined sine and cosine of one folded angle by Horner steps in Q30,
// unfolded by quadrant and rounded to the output format.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module e2r_trig import e2r_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  angle_class_t                    cls,
	output logic signed [FRACTION_BITS+1:0] sin_s20,
	output logic signed [FRACTION_BITS+1:0] cos_s20
);

	localparam int OW        = FRACTION_BITS + 2;
	localparam int SHIFT_OUT = Q_BITS - FRACTION_BITS;
	localparam logic signed [31:0] HALF_OUT = 32'sd1 <<< (SHIFT_OUT - 1);
	localparam int X2_TAPS  = STEP_LAT * (COS_STEPS - 1);
	localparam int X_TAPS   = STEP_LAT * SIN_STEPS;
	localparam int CLS_TAPS = STEP_LAT * COS_STEPS;

	logic [61:0]  x_prod_s1;
	angle_class_t cls_s1, cls_s2, cls_s3, cls_s4;
	logic [29:0]  x_s2, x_s3, x_s4;
	logic [59:0]  x2_prod_s3;
	logic [29:0]  x2_s4;
	logic [62:0]  x_sum;
	logic [60:0]  x2_sum;

	logic [29:0]  x2_dl_q  [1:X2_TAPS];
	logic [29:0]  x_dl_q   [1:X_TAPS];
	angle_class_t cls_dl_q [1:CLS_TAPS];

	logic [30:0]  sin_h_q [1:SIN_STEPS];
	logic [30:0]  cos_h_q [1:COS_STEPS];

	logic [60:0]  sprod_q;
	logic [61:0]  s_sum;
	logic [30:0]  s_q, s_pad_q;

	logic [30:0]        s_sel, c_sel;
	logic signed [31:0] ss, cc, rs, rc;

	// Radian value of the folded angle, then its square.
	assign x_sum  = 63'(x_prod_s1) + 63'(ONE_Q30);
	assign x2_sum = 61'(x2_prod_s3) + 61'(HALF_Q30);

	always_ff @(posedge clk) begin
		x_prod_s1  <= 62'(cls.red) * 62'(PI_Q30);
		cls_s1     <= cls;
		x_s2       <= x_sum[60:31];
		cls_s2     <= cls_s1;
		x2_prod_s3 <= 60'(x_s2) * 60'(x_s2);
		x_s3       <= x_s2;
		cls_s3     <= cls_s2;
		x2_s4      <= x2_sum[59:30];
		x_s4       <= x_s3;
		cls_s4     <= cls_s3;
	end

	// Delay lines that follow the Horner steps.
	always_ff @(posedge clk) begin
		x2_dl_q[1]  <= x2_s4;
		x_dl_q[1]   <= x_s4;
		cls_dl_q[1] <= cls_s4;
		for (int j = 2; j <= X2_TAPS; j++) begin
			x2_dl_q[j] <= x2_dl_q[j-1];
		end
		for (int j = 2; j <= X_TAPS; j++) begin
			x_dl_q[j] <= x_dl_q[j-1];
		end
		for (int j = 2; j <= CLS_TAPS; j++) begin
			cls_dl_q[j] <= cls_dl_q[j-1];
		end
	end

	// Sine series: h = 1 - x2*h/d; a step registers prod_q, then n_q and p_q, then h.
	for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
		localparam logic [6:0]  D = sin_div(k);
		localparam logic [32:0] M = 33'((64'd1 << RECIP_SHIFT) / D);

		logic [29:0] x2_op;
		logic [30:0] h_op;
		logic [60:0] prod_q;
		logic [30:0] n_q;
		logic [63:0] p_q;
		logic [61:0] n_sum;
		logic [30:0] n_c, q0, rem, quo;

		if (k == 0) begin : g_first
			assign x2_op = x2_s4;
			assign h_op  = ONE_Q30;
		end else begin : g_next
			assign x2_op = x2_dl_q[STEP_LAT*k];
			assign h_op  = sin_h_q[k];
		end

		// Round the product, then divide by reciprocal with one correction.
		always_comb begin
			n_sum = 62'(prod_q) + 62'(HALF_Q30);
			n_c   = n_sum[60:30];
			q0    = p_q[63:33];
			rem   = n_q - 31'(q0 * 31'(D));
			quo   = q0 + 31'(rem >= 31'(D));
		end

		always_ff @(posedge clk) begin
			prod_q         <= 61'(x2_op) * 61'(h_op);
			n_q            <= n_c;
			p_q            <= 64'(n_c) * 64'(M);
			sin_h_q[k+1]   <= ONE_Q30 - quo;
		end
	end

	// Cosine series, same step structure.
	for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
		localparam logic [6:0]  D = cos_div(k);
		localparam logic [32:0] M = 33'((64'd1 << RECIP_SHIFT) / D);

		logic [29:0] x2_op;
		logic [30:0] h_op;
		logic [60:0] prod_q;
		logic [30:0] n_q;
		logic [63:0] p_q;
		logic [61:0] n_sum;
		logic [30:0] n_c, q0, rem, quo;

		if (k == 0) begin : g_first
			assign x2_op = x2_s4;
			assign h_op  = ONE_Q30;
		end else begin : g_next
			assign x2_op = x2_dl_q[STEP_LAT*k];
			assign h_op  = cos_h_q[k];
		end

		always_comb begin
			n_sum = 62'(prod_q) + 62'(HALF_Q30);
			n_c   = n_sum[60:30];
			q0    = p_q[63:33];
			rem   = n_q - 31'(q0 * 31'(D));
			quo   = q0 + 31'(rem >= 31'(D));
		end

		always_ff @(posedge clk) begin
			prod_q         <= 61'(x2_op) * 61'(h_op);
			n_q            <= n_c;
			p_q            <= 64'(n_c) * 64'(M);
			cos_h_q[k+1]   <= ONE_Q30 - quo;
		end
	end

	// Sine tail: s = x*h, rounded, then padded to line up with the cosine.
	assign s_sum = 62'(sprod_q) + 62'(HALF_Q30);

	always_ff @(posedge clk) begin
		sprod_q <= 61'(x_dl_q[X_TAPS]) * 61'(sin_h_q[SIN_STEPS]);
		s_q     <= s_sum[60:30];
		s_pad_q <= s_q;
	end

	// Undo the reflection and the quadrant fold.
	always_comb begin
		s_sel = cls_dl_q[CLS_TAPS].swap ? cos_h_q[COS_STEPS] : s_pad_q;
		c_sel = cls_dl_q[CLS_TAPS].swap ? s_pad_q : cos_h_q[COS_STEPS];
		ss    = signed'({1'b0, s_sel});
		cc    = signed'({1'b0, c_sel});
		unique case (cls_dl_q[CLS_TAPS].quad)
			QUAD_0: begin
				rs = ss;
				rc = cc;
			end
			QUAD_1: begin
				rs = cc;
				rc = -ss;
			end
			QUAD_2: begin
				rs = -ss;
				rc = -cc;
			end
			QUAD_3: begin
				rs = -cc;
				rc = ss;
			end
		endcase
	end

	// Round half up to the output format.
	always_ff @(posedge clk) begin
		sin_s20 <= OW'((rs + HALF_OUT) >>> SHIFT_OUT);
		cos_s20 <= OW'((rc + HALF_OUT) >>> SHIFT_OUT);
	end

endmodule

/* rtl/core/e2r_back.sv */
// -----------------------------------------------------------------------------
// e2r_back
// Takes classified items under output credit, computes the three sine and
// cosine pairs and forms the nine matrix entries in a fixed pipeline.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "euler_to_rotation_matrix_core_macros.svh"

module e2r_back import e2r_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fold_item_t                        item,
	input  logic                              item_empty,
	output logic                              deq,
	input  logic                              out_take,
	output logic                              out_push,
	output logic [9*(FRACTION_BITS+2)-1:0]    out_data
);

	localparam int OW    = FRACTION_BITS + 2;
	localparam int PW    = 2 * OW;
	localparam int SW    = PW + 1;
	localparam int RSV_W = $clog2(OUT_DEPTH) + 1;
	localparam logic signed [PW-1:0] HALF_PW = PW'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [SW-1:0] HALF_SW = SW'(1) <<< (FRACTION_BITS - 1);
	localparam logic signed [SW-1:0] LIM_SW  = SW'(1) <<< FRACTION_BITS;

	logic [RSV_W-1:0]    reserved_q;
	logic [BACK_LAT-1:0] vld_q;

	logic signed [OW-1:0] sr_s20, cr_s20, sp_s20, cp_s20, sy_s20, cy_s20;
	logic signed [OW-1:0] sr_s21, cr_s21, sp_s21, cp_s21, sy_s21, cy_s21;
	logic signed [PW-1:0] csp_p_s21, ssp_p_s21;
	logic signed [OW-1:0] sr_s22, cr_s22, sp_s22, cp_s22, sy_s22, cy_s22;
	logic signed [OW-1:0] csp_s22, ssp_s22;
	logic signed [OW-1:0] sp_s23;
	logic signed [PW-1:0] p_ssp_sr_s23, p_cy_cr_s23, p_cp_sr_s23, p_csp_sr_s23;
	logic signed [PW-1:0] p_sy_cr_s23, p_ssp_cr_s23, p_cy_sr_s23, p_cp_cr_s23;
	logic signed [PW-1:0] p_csp_cr_s23, p_sy_sr_s23, p_sy_cp_s23, p_cy_cp_s23;
	logic signed [OW:0]   neg_sp;
	logic signed [OW-1:0] v0_s24, v1_s24, v2_s24, v3_s24, v4_s24;
	logic signed [OW-1:0] v5_s24, v6_s24, v7_s24, v8_s24;

	// Round half up by FRACTION_BITS and clamp to plus or minus one.
	function automatic logic signed [OW-1:0] sat_rnd(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		logic signed [OW-1:0] o;
		r = (v + HALF_SW) >>> FRACTION_BITS;
		priority if (r > LIM_SW) begin
			o = OW'(LIM_SW);
		end else if (r < -LIM_SW) begin
			o = OW'(-LIM_SW);
		end else begin
			o = OW'(r);
		end
		return o;
	endfunction

	// An item enters only if the output queue has room for everything in flight.
	assign deq = !item_empty && (reserved_q < RSV_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
			vld_q      <= '0;
		end else begin
			vld_q <= {vld_q[BACK_LAT-2:0], deq};
			unique case ({deq, out_take})
				2'b10:   reserved_q <= reserved_q + 1'b1;
				2'b01:   reserved_q <= reserved_q - 1'b1;
				default: reserved_q <= reserved_q;
			endcase
		end
	end

	// Sine and cosine units, one per angle.
	e2r_trig #(.FRACTION_BITS(FRACTION_BITS)) u_trig_roll (
		.clk     (clk),
		.cls     (item.roll),
		.sin_s20 (sr_s20),
		.cos_s20 (cr_s20)
	);

	e2r_trig #(.FRACTION_BITS(FRACTION_BITS)) u_trig_pitch (
		.clk     (clk),
		.cls     (item.pitch),
		.sin_s20 (sp_s20),
		.cos_s20 (cp_s20)
	);

	e2r_trig #(.FRACTION_BITS(FRACTION_BITS)) u_trig_yaw (
		.clk     (clk),
		.cls     (item.yaw),
		.sin_s20 (sy_s20),
		.cos_s20 (cy_s20)
	);

	// Shared partial products cosY*sinP and sinY*sinP.
	always_ff @(posedge clk) begin
		csp_p_s21 <= cy_s20 * sp_s20;
		ssp_p_s21 <= sy_s20 * sp_s20;
		sr_s21    <= sr_s20;
		cr_s21    <= cr_s20;
		sp_s21    <= sp_s20;
		cp_s21    <= cp_s20;
		sy_s21    <= sy_s20;
		cy_s21    <= cy_s20;
	end

	// Round the shared products back to the output format.
	always_ff @(posedge clk) begin
		csp_s22 <= OW'((csp_p_s21 + HALF_PW) >>> FRACTION_BITS);
		ssp_s22 <= OW'((ssp_p_s21 + HALF_PW) >>> FRACTION_BITS);
		sr_s22  <= sr_s21;
		cr_s22  <= cr_s21;
		sp_s22  <= sp_s21;
		cp_s22  <= cp_s21;
		sy_s22  <= sy_s21;
		cy_s22  <= cy_s21;
	end

	// Full-precision products of every entry but v7, which is the negated sine of pitch.
	always_ff @(posedge clk) begin
		p_ssp_sr_s23 <= ssp_s22 * sr_s22;
		p_cy_cr_s23  <= cy_s22 * cr_s22;
		p_cp_sr_s23  <= cp_s22 * sr_s22;
		p_csp_sr_s23 <= csp_s22 * sr_s22;
		p_sy_cr_s23  <= sy_s22 * cr_s22;
		p_ssp_cr_s23 <= ssp_s22 * cr_s22;
		p_cy_sr_s23  <= cy_s22 * sr_s22;
		p_cp_cr_s23  <= cp_s22 * cr_s22;
		p_csp_cr_s23 <= csp_s22 * cr_s22;
		p_sy_sr_s23  <= sy_s22 * sr_s22;
		p_sy_cp_s23  <= sy_s22 * cp_s22;
		p_cy_cp_s23  <= cy_s22 * cp_s22;
		sp_s23       <= sp_s22;
	end

	// Negated sine of pitch stays within range, so no clamp is needed.
	assign neg_sp = -((OW+1)'(sp_s23));

	// Entries rounded once, then clamped; v7 takes the negated sine of pitch as it is.
	always_ff @(posedge clk) begin
		v0_s24 <= sat_rnd(SW'(p_ssp_sr_s23) + SW'(p_cy_cr_s23));
		v1_s24 <= sat_rnd(SW'(p_cp_sr_s23));
		v2_s24 <= sat_rnd(SW'(p_csp_sr_s23) - SW'(p_sy_cr_s23));
		v3_s24 <= sat_rnd(SW'(p_ssp_cr_s23) - SW'(p_cy_sr_s23));
		v4_s24 <= sat_rnd(SW'(p_cp_cr_s23));
		v5_s24 <= sat_rnd(SW'(p_csp_cr_s23) + SW'(p_sy_sr_s23));
		v6_s24 <= sat_rnd(SW'(p_sy_cp_s23));
		v7_s24 <= OW'(neg_sp);
		v8_s24 <= sat_rnd(SW'(p_cy_cp_s23));
	end

	assign out_push = vld_q[BACK_LAT-1];
	assign out_data = {v0_s24, v1_s24, v2_s24, v3_s24, v4_s24,
	                   v5_s24, v6_s24, v7_s24, v8_s24};

	`E2R_ASSERT(a_credit_bound, reserved_q <= RSV_W'(OUT_DEPTH), "output credit overrun")
	`E2R_ASSERT(a_push_reserved, !out_push || (reserved_q != '0), "result without credit")
	`E2R_ASSERT_NEXT(a_issue_counts, deq && !out_take, reserved_q == $past(reserved_q) + 1'b1, "issue not counted")

endmodule

/* rtl/core/euler_to_rotation_matrix_core.sv */
// -----------------------------------------------------------------------------
// euler_to_rotation_matrix_core: roll, pitch and yaw to a 3x3 rotation matrix.
// Throughput: one item per cycle while output credit lasts; every multiplier stage
// is pipelined and the 32-entry output queue covers the 24 stages of the back end.
// Reset: arst_n clears both queues and the pipeline valid bits at once.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_to_rotation_matrix_core import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic signed [ANGLE_WIDTH-1:0]   roll_angle,
	input  logic signed [ANGLE_WIDTH-1:0]   pitch_angle,
	input  logic signed [ANGLE_WIDTH-1:0]   yaw_angle,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [FRACTION_BITS+1:0] x_axis_x,
	output logic signed [FRACTION_BITS+1:0] x_axis_y,
	output logic signed [FRACTION_BITS+1:0] x_axis_z,
	output logic signed [FRACTION_BITS+1:0] y_axis_x,
	output logic signed [FRACTION_BITS+1:0] y_axis_y,
	output logic signed [FRACTION_BITS+1:0] y_axis_z,
	output logic signed [FRACTION_BITS+1:0] z_axis_x,
	output logic signed [FRACTION_BITS+1:0] z_axis_y,
	output logic signed [FRACTION_BITS+1:0] z_axis_z
);

	localparam int OW = FRACTION_BITS + 2;

	fold_item_t        mid_item;
	logic              mid_empty;
	logic              mid_deq;
	logic              res_push;
	logic [9*OW-1:0]   res_data;
	logic [9*OW-1:0]   res_rd;
	logic              res_take;

	assign res_take = pop && !empty;

	// Front end: classify and queue.
	e2r_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.roll_angle  (roll_angle),
		.pitch_angle (pitch_angle),
		.yaw_angle   (yaw_angle),
		.deq         (mid_deq),
		.item        (mid_item),
		.item_empty  (mid_empty)
	);

	// Back end: trigonometry and matrix products.
	e2r_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (mid_item),
		.item_empty (mid_empty),
		.deq        (mid_deq),
		.out_take   (res_take),
		.out_push   (res_push),
		.out_data   (res_data)
	);

	// Result queue toward the consumer.
	e2r_fifo #(
		.WIDTH (9 * OW),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_data),
		.full    (),
		.pop     (pop),
		.rd_data (res_rd),
		.empty   (empty)
	);

	assign x_axis_x = res_rd[8*OW +: OW];
	assign x_axis_y = res_rd[7*OW +: OW];
	assign x_axis_z = res_rd[6*OW +: OW];
	assign y_axis_x = res_rd[5*OW +: OW];
	assign y_axis_y = res_rd[4*OW +: OW];
	assign y_axis_z = res_rd[3*OW +: OW];
	assign z_axis_x = res_rd[2*OW +: OW];
	assign z_axis_y = res_rd[1*OW +: OW];
	assign z_axis_z = res_rd[0 +: OW];

endmodule

/* verif/tb_euler_to_rotation_matrix_core.sv */
// -----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix_core
// Drives roll, pitch and yaw items into the rotation matrix core and checks
// every matrix against a fixed-point predictor kept in this bench or a typed
// expected matrix. A short table of corner angles comes first, then random
// angles over several phases of sender idling and receiver stalls.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_to_rotation_matrix_core;
	import e2r_pkg::*;

	localparam longint unsigned K_PI  = 64'd3373259426;
	localparam longint unsigned K_ONE = 64'd1 << 30;
	localparam int FB = 14;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1500;

	typedef logic [8:0][15:0] matrix_t;

	typedef struct {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
		bit          typed;
		matrix_t     want;
	} angle_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [15:0] roll_angle = '0, pitch_angle = '0, yaw_angle = '0;
	logic signed [15:0] x_axis_x, x_axis_y, x_axis_z;
	logic signed [15:0] y_axis_x, y_axis_y, y_axis_z;
	logic signed [15:0] z_axis_x, z_axis_y, z_axis_z;

	matrix_t pending_matrices[$];
	int error_count = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	string field_names[9] = '{"x_axis_x", "x_axis_y", "x_axis_z", "y_axis_x", "y_axis_y",
		"y_axis_z", "z_axis_x", "z_axis_y", "z_axis_z"};

	euler_to_rotation_matrix_core dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.empty(empty), .pop(pop),
		.x_axis_x(x_axis_x), .x_axis_y(x_axis_y), .x_axis_z(x_axis_z),
		.y_axis_x(y_axis_x), .y_axis_y(y_axis_y), .y_axis_z(y_axis_z),
		.z_axis_x(z_axis_x), .z_axis_y(z_axis_y), .z_axis_z(z_axis_z)
	);

	always #1 clk = ~clk;

	// Q30 product, rounded half up.
	function automatic longint unsigned q30_mul(input longint unsigned a, input longint unsigned b);
		return (a * b + (K_ONE >> 1)) >> 30;
	endfunction

	// Round half up by dropping k fraction bits.
	function automatic longint round_shift(input longint v, input int k);
		return (v + (64'sd1 <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clamp_unit(input longint v);
		if (v > (64'sd1 <<< FB)) return 64'sd1 <<< FB;
		if (v < -(64'sd1 <<< FB)) return -(64'sd1 <<< FB);
		return v;
	endfunction

	// Sine and cosine of the negated binary angle, in Q1.14.
	task automatic neg_angle_sincos(input logic [15:0] a, output longint s_out,
		output longint c_out);
		logic [31:0] turn;
		longint unsigned r, x, x2, h, sv, cv, tmp;
		longint rs, rc;
		quad_t quad;
		turn = 32'd0 - {a, 16'd0};
		quad = quad_t'(turn[31:30]);
		r = {34'd0, turn[29:0]};
		tmp = 0;
		if (r > 64'h2000_0000) begin
			r = 64'h4000_0000 - r;
			tmp = 1;
		end
		x = (r * K_PI + K_ONE) >> 31;
		x2 = q30_mul(x, x);
		// Sine series to x^9.
		h = K_ONE - x2 / 72;
		h = K_ONE - q30_mul(x2, h) / 42;
		h = K_ONE - q30_mul(x2, h) / 20;
		h = K_ONE - q30_mul(x2, h) / 6;
		sv = q30_mul(x, h);
		// Cosine series to x^10.
		h = K_ONE - x2 / 90;
		h = K_ONE - q30_mul(x2, h) / 56;
		h = K_ONE - q30_mul(x2, h) / 30;
		h = K_ONE - q30_mul(x2, h) / 12;
		cv = K_ONE - q30_mul(x2, h) / 2;
		if (tmp != 0) begin
			tmp = sv;
			sv = cv;
			cv = tmp;
		end
		case (quad)
			QUAD_0: begin rs = sv; rc = cv; end
			QUAD_1: begin rs = cv; rc = -longint'(sv); end
			QUAD_2: begin rs = -longint'(sv); rc = -longint'(cv); end
			default: begin rs = -longint'(cv); rc = sv; end
		endcase
		s_out = round_shift(rs, 30 - FB);
		c_out = round_shift(rc, 30 - FB);
	endtask

	// Rotation matrix that the core should produce for one item.
	task automatic predict_matrix(input logic [15:0] roll, input logic [15:0] pitch,
		input logic [15:0] yaw, output matrix_t m);
		longint sr, cr, sp, cp, sy, cy, csp, ssp;
		longint v[9];
		neg_angle_sincos(roll, sr, cr);
		neg_angle_sincos(pitch, sp, cp);
		neg_angle_sincos(yaw, sy, cy);
		csp = round_shift(cy * sp, FB);
		ssp = round_shift(sy * sp, FB);
		v[0] = round_shift(ssp * sr + cy * cr, FB);
		v[1] = round_shift(cp * sr, FB);
		v[2] = round_shift(csp * sr - sy * cr, FB);
		v[3] = round_shift(ssp * cr - cy * sr, FB);
		v[4] = round_shift(cp * cr, FB);
		v[5] = round_shift(csp * cr + sy * sr, FB);
		v[6] = round_shift(sy * cp, FB);
		v[7] = -sp;
		v[8] = round_shift(cy * cp, FB);
		for (int i = 0; i < 9; i++)
			m[i] = 16'(clamp_unit(v[i]));
	endtask

	task automatic report_mismatch(input int field, input logic [15:0] got,
		input logic [15:0] want);
		error_count++;
		$display("ERROR %0t: %s got %0d expected %0d", $time, field_names[field],
			$signed(got), $signed(want));
	endtask

	// Offer one item, idling at random, until the core takes it.
	task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
		input logic [15:0] yaw, input bit typed, input matrix_t want);
		matrix_t m;
		forever begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				roll_angle <= roll;
				pitch_angle <= pitch;
				yaw_angle <= yaw;
				@(posedge clk);
				if (!full)
					break;
			end
		end
		if (typed)
			m = want;
		else
			predict_matrix(roll, pitch, yaw, m);
		pending_matrices.push_back(m);
	endtask

	// Random angle, weighted toward quadrant and octant boundaries.
	function automatic logic [15:0] pick_angle();
		logic [15:0] a;
		case ($urandom_range(3))
			0: a = {3'($urandom_range(7)), 13'd0};
			1: a = {3'($urandom_range(7)), 13'd0} + 16'($signed($urandom_range(4)) - 2);
			default: a = 16'($urandom());
		endcase
		return a;
	endfunction

	// Receiver stalls at the rate of the current phase.
	always @(negedge clk)
		pop <= ($urandom_range(99) >= stall_pct);

	// Check each matrix the core hands over against the oldest prediction.
	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && pop && !empty) begin
			got = {z_axis_z, z_axis_y, z_axis_x, y_axis_z, y_axis_y, y_axis_x,
				x_axis_z, x_axis_y, x_axis_x};
			if (pending_matrices.size() == 0) begin
				error_count++;
				$display("ERROR %0t: matrix with no item outstanding", $time);
			end else begin
				want = pending_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== want[i])
						report_mismatch(i, got[i], want[i]);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	angle_row_t corner_rows[] = '{
		'{16'h0000, 16'h0000, 16'h0000, 1'b1,
			{16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, 16'd16384}},
		'{16'h8000, 16'h0000, 16'h0000, 1'b1,
			{16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384}},
		'{16'h0000, 16'h8000, 16'h0000, 1'b0, '0},
		'{16'h0000, 16'h0000, 16'h8000, 1'b0, '0},
		'{16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, '0},
		'{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
		'{16'h4000, 16'h0000, 16'h0000, 1'b0, '0},
		'{16'h0000, 16'h4000, 16'h0000, 1'b0, '0},
		'{16'h0000, 16'h0000, 16'h4000, 1'b0, '0},
		'{16'hC000, 16'hC000, 16'hC000, 1'b0, '0},
		'{16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
		'{16'h2001, 16'h1FFF, 16'hE000, 1'b0, '0},
		'{16'h6000, 16'hA000, 16'hE001, 1'b0, '0},
		'{16'h0001, 16'hFFFF, 16'h8001, 1'b0, '0},
		'{16'h1234, 16'hEDCB, 16'h5555, 1'b0, '0},
		'{16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, '0}
	};

	// Stimulus: corner table, then random angles over the idling and stall phases.
	initial begin
		int idle_phase[4] = '{0, 65, 0, 11};
		int stall_phase[4] = '{0, 0, 65, 11};
		int wait_cycles;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (corner_rows[i])
			send_angles(corner_rows[i].roll, corner_rows[i].pitch, corner_rows[i].yaw,
				corner_rows[i].typed, corner_rows[i].want);
		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_phase[p];
			stall_pct = stall_phase[p];
			for (int n = 0; n < RANDOM_ITEMS / 4; n++)
				send_angles(pick_angle(), pick_angle(), pick_angle(), 1'b0, '0);
		end
		@(negedge clk);
		push <= 1'b0;
		// Drain, then let the pipeline settle.
		wait_cycles = 0;
		while (pending_matrices.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (error_count == 0 && pending_matrices.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
